/* rtl/mos_pkg.sv */
// Package for the nonnegative-sample median block.
// Sizing constants and sequencer state type; no dependencies.
package mos_pkg;

  localparam int MAX_SAMPLES = 64;                    // store depth, 2..127
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int SAMPLE_W    = 32;                    // Q16.16 signed
  localparam int VAL_W       = SAMPLE_W - 1;          // nonnegative magnitude
  localparam int KEPT_W      = 7;                     // kept_count field width

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for an item
    ST_RD,     // read neighbor below insert slot
    ST_CMP,    // compare neighbor, shift up or stop
    ST_WR,     // drop new value into its slot
    ST_MED_A,  // read lower middle entry
    ST_MED_B,  // latch lower, read upper middle entry
    ST_MED_C   // add and present result
  } state_t;

endpackage

/* rtl/median_of_nonnegative_set.sv */
// Top level: median of the nonnegative samples of a set, via insertion sort.
// Depends on mos_pkg (sizing constants, state_t).
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+---------------------------
//  input   | in_sample[31:0] (signed), in_last             | start & !busy
//  result  | out_median_twice, out_valid_res, out_overflow,| out_strobe, one cycle,
//          | out_kept_count[6:0]                           | cannot be held off
//
// Steps: a negative or dropped sample is handled in ST_IDLE alone. A kept
// sample takes one RD/CMP pair per shifted entry, plus one more pair for the
// compare that stops the scan unless it sinks to slot 0 (no pair at all for
// an empty store), then the write.
// An item with in_last set adds the two middle reads and the add (only
// ST_MED_A for an empty set); the result strobe follows in the next cycle.
// The store port sets the rate.
// Reset (rst_n low, synchronous) empties the set; store contents stay
// undefined and are never read before being written within a set.
// The receiver cannot stall: each result is shown for exactly one cycle.
module median_of_nonnegative_set
  import mos_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last,
  output logic                       out_strobe,
  output logic [SAMPLE_W-1:0]        out_median_twice,
  output logic                       out_valid_res,
  output logic                       out_overflow,
  output logic [KEPT_W-1:0]          out_kept_count
);

  // sorted store, ascending; single write port, one registered read port
  logic [VAL_W-1:0] mem [MAX_SAMPLES];

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;         // kept samples in this set
  logic              ovf_r, ovf_nxt;         // a sample was dropped
  logic [VAL_W-1:0]  v_r, v_nxt;             // value being inserted
  logic [ADDR_W-1:0] pos_r, pos_nxt;         // current hole in the store
  logic              last_r, last_nxt;       // item closes the set
  logic [VAL_W-1:0]  rd_data_r;
  logic [VAL_W-1:0]  lo_r, lo_nxt;           // lower middle entry

  logic                out_strobe_r, out_strobe_nxt;
  logic [SAMPLE_W-1:0] med_r, med_nxt;
  logic                vres_r, vres_nxt;
  logic                oovf_r, oovf_nxt;
  logic [KEPT_W-1:0]   kept_r, kept_nxt;

  // store port controls
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [VAL_W-1:0]  wdata;
  logic [ADDR_W-1:0] raddr;

  logic              accept;
  logic              nonneg;
  logic              room;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W+KEPT_W-1:0] kept_ext;        // zero-extended count; its low KEPT_W bits give kept_count

  assign accept   = start && (state_r == ST_IDLE);
  assign nonneg   = !in_sample[SAMPLE_W-1];
  assign room     = (cnt_r < CNT_W'(MAX_SAMPLES));
  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign kept_ext = {{KEPT_W{1'b0}}, cnt_r};

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ovf_nxt        = ovf_r;
    v_nxt          = v_r;
    pos_nxt        = pos_r;
    last_nxt       = last_r;
    lo_nxt         = lo_r;
    out_strobe_nxt = 1'b0;
    med_nxt        = med_r;
    vres_nxt       = vres_r;
    oovf_nxt       = oovf_r;
    kept_nxt       = kept_r;
    we             = 1'b0;
    waddr          = pos_r;
    wdata          = v_r;
    raddr          = pos_r - ADDR_W'(1);

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          last_nxt = in_last;
          v_nxt    = in_sample[VAL_W-1:0];
          if (nonneg && room) begin
            pos_nxt   = cnt_r[ADDR_W-1:0];
            state_nxt = (cnt_r == '0) ? ST_WR : ST_RD;
          end else begin
            if (nonneg) ovf_nxt = 1'b1;
            state_nxt = in_last ? ST_MED_A : ST_IDLE;
          end
        end
      end
      ST_RD: begin
        // read issued at pos-1 by default raddr
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (rd_data_r > v_r) begin
          // move larger neighbor up one slot
          we        = 1'b1;
          wdata     = rd_data_r;
          pos_nxt   = pos_r - ADDR_W'(1);
          state_nxt = (pos_r == ADDR_W'(1)) ? ST_WR : ST_RD;
        end else begin
          state_nxt = ST_WR;
        end
      end
      ST_WR: begin
        we        = 1'b1;
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = last_r ? ST_MED_A : ST_IDLE;
      end
      ST_MED_A: begin
        if (cnt_r == '0) begin
          // empty set
          out_strobe_nxt = 1'b1;
          med_nxt        = '0;
          vres_nxt       = 1'b0;
          oovf_nxt       = ovf_r;
          kept_nxt       = '0;
          ovf_nxt        = 1'b0;
          state_nxt      = ST_IDLE;
        end else begin
          raddr     = ADDR_W'(cnt_m1 >> 1);      // (n-1)/2
          state_nxt = ST_MED_B;
        end
      end
      ST_MED_B: begin
        lo_nxt    = rd_data_r;
        raddr     = ADDR_W'(cnt_r >> 1);         // n/2
        state_nxt = ST_MED_C;
      end
      ST_MED_C: begin
        // odd count reads the middle twice, even count the two middles
        out_strobe_nxt = 1'b1;
        med_nxt        = SAMPLE_W'(lo_r) + SAMPLE_W'(rd_data_r);
        vres_nxt       = 1'b1;
        oovf_nxt       = ovf_r;
        kept_nxt       = kept_ext[KEPT_W-1:0];
        cnt_nxt        = '0;
        ovf_nxt        = 1'b0;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      ovf_r        <= ovf_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    pos_r  <= pos_nxt;
    last_r <= last_nxt;
    lo_r   <= lo_nxt;
    med_r  <= med_nxt;
    vres_r <= vres_nxt;
    oovf_r <= oovf_nxt;
    kept_r <= kept_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_median_twice = med_r;
  assign out_valid_res    = vres_r;
  assign out_overflow     = oovf_r;
  assign out_kept_count   = kept_r;

endmodule
